// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the XTEA IGE cipher block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every aclk edge while aresetn is high.
`define XTEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every aclk edge, reset included.
`define XTEA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA IGE package
// Types, constants and helper functions shared by the cipher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;
    localparam logic [6:0]  ROUNDS_RESET = 7'd32;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_ROUNDS = 3'd4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [3:0][31:0] key_t;

    typedef struct packed {
        logic start;
        logic decrypt;
        logic ack;
    } eng_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        mix_word = ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xtea_round.sv =====
// ----------------------------------------------------------------------------
// XTEA round unit
// One full XTEA round, forward or inverse, on the y and z words.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_round
    import xtea_pkg::*;
(
    input  wire logic [31:0] y_in,
    input  wire logic [31:0] z_in,
    input  wire logic [31:0] sum_in,
    input  wire key_t        key,
    input  wire logic        decrypt,
    output logic      [31:0] y_out,
    output logic      [31:0] z_out,
    output logic      [31:0] sum_out
);

    logic [31:0] sum_mid;
    logic [31:0] enc_y;
    logic [31:0] dec_z;

    always_comb begin
        sum_mid = decrypt ? (sum_in - XTEA_DELTA) : (sum_in + XTEA_DELTA);
        enc_y   = y_in + (mix_word(z_in) ^ (sum_in + key[sum_in[1:0]]));
        dec_z   = z_in - (mix_word(y_in) ^ (sum_in + key[sum_in[12:11]]));
        if (decrypt) begin
            z_out = dec_z;
            y_out = y_in - (mix_word(dec_z) ^ (sum_mid + key[sum_mid[1:0]]));
        end else begin
            y_out = enc_y;
            z_out = z_in + (mix_word(enc_y) ^ (sum_mid + key[sum_mid[12:11]]));
        end
        sum_out = sum_mid;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_engine.sv =====
// ----------------------------------------------------------------------------
// XTEA round engine
// Runs the configured number of rounds through one shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module xtea_engine
    import xtea_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire eng_ctrl_t        ctrl,
    input  wire logic [CNT_W-1:0] rounds,
    input  wire key_t             key,
    input  wire logic [63:0]      blk_in,
    output eng_stat_t             stat,
    output logic      [63:0]      blk_out
);

    typedef enum logic [2:0] {
        ENG_IDLE  = 3'b001,
        ENG_ROUND = 3'b010,
        ENG_DONE  = 3'b100
    } eng_state_t;

    eng_state_t       state_reg, state_next;
    logic [31:0]      y_reg, z_reg, sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             dec_reg;
    logic [31:0]      y_rnd, z_rnd, sum_rnd;
    logic [31+CNT_W:0] sum_prod;

    xtea_round u_round (
        .y_in    (y_reg),
        .z_in    (z_reg),
        .sum_in  (sum_reg),
        .key     (key),
        .decrypt (dec_reg),
        .y_out   (y_rnd),
        .z_out   (z_rnd),
        .sum_out (sum_rnd)
    );

    assign sum_prod = {{CNT_W{1'b0}}, XTEA_DELTA} * {32'b0, rounds};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: begin
                if (ctrl.start) begin
                    state_next = (rounds == '0) ? ENG_DONE : ENG_ROUND;
                end
            end
            ENG_ROUND: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ENG_DONE;
                end
            end
            ENG_DONE: begin
                if (ctrl.ack) begin
                    state_next = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ENG_IDLE && ctrl.start) begin
                cnt_reg <= rounds;
            end else if (state_reg == ENG_ROUND) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ENG_IDLE && ctrl.start) begin
            y_reg   <= blk_in[31:0];
            z_reg   <= blk_in[63:32];
            dec_reg <= ctrl.decrypt;
            sum_reg <= (ctrl.decrypt == OP_DECRYPT) ? sum_prod[31:0] : 32'd0;
        end else if (state_reg == ENG_ROUND) begin
            y_reg   <= y_rnd;
            z_reg   <= z_rnd;
            sum_reg <= sum_rnd;
        end
    end

    assign stat.idle = (state_reg == ENG_IDLE);
    assign stat.done = (state_reg == ENG_DONE);
    assign blk_out   = {z_reg, y_reg};

    `XTEA_ASSERT(a_done_cnt_zero, state_reg == ENG_DONE |-> cnt_reg == '0, "done with rounds left")
    `XTEA_ASSERT(a_start_idle, ctrl.start |-> state_reg == ENG_IDLE, "start while busy")
    `XTEA_ASSERT(a_ack_done, ctrl.ack |-> state_reg == ENG_DONE, "ack without a result")

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_ige_chained_cipher.sv =====
// ----------------------------------------------------------------------------
// XTEA IGE chained cipher
// XTEA encrypt or decrypt of 64-bit blocks with IGE chaining and trailer flag.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   tdata {data_high, data_low}, tuser {first_block, opcode}
// m_*      out  tdata {result_high, result_low}, tuser {tail_zero}
// cfg_*    in   register write: key words 0-3, round count
//
// A word is finished before the next one is accepted. The engine runs R
// rounds, with R the round count saturated to MAX_ROUNDS; the shared round unit does one
// round per cycle. Reset is synchronous, clears the chaining blocks and the
// key, and sets the round count to 32.
// A stalled result holds the engine in its done state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module xtea_ige_chained_cipher
    import xtea_pkg::*;
#(
    parameter int MAX_ROUNDS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // data_low, data_high
    input  wire logic [1:0]  s_tuser,   // opcode, first_block
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // result_low, result_high
    output logic      [0:0]  m_tuser    // tail_zero
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    key_t             key_reg;
    logic [6:0]       round_count_reg;
    logic [63:0]      chain_cipher_reg, chain_plain_reg;
    logic [63:0]      blk_reg;
    logic             op_reg;
    logic             m_valid_reg;
    logic [63:0]      m_data_reg;
    logic             m_tail_reg;

    logic             s_accept, finish;
    logic [63:0]      cc_eff, cp_eff, core_in, core_out, res;
    logic [7:0]       rounds_wide;
    logic [CNT_W-1:0] rounds;
    eng_ctrl_t        eng_ctrl;
    eng_stat_t        eng_stat;

    assign rounds_wide = ({1'b0, round_count_reg} > 8'(MAX_ROUNDS)) ?
                         8'(MAX_ROUNDS) : {1'b0, round_count_reg};
    assign rounds = rounds_wide[CNT_W-1:0];

    assign s_tready = eng_stat.idle;
    assign s_accept = s_tvalid && s_tready;
    assign finish   = eng_stat.done && (!m_valid_reg || m_tready);

    assign cc_eff  = s_tuser[1] ? 64'd0 : chain_cipher_reg;
    assign cp_eff  = s_tuser[1] ? 64'd0 : chain_plain_reg;
    assign core_in = s_tdata ^ ((s_tuser[0] == OP_DECRYPT) ? cp_eff : cc_eff);
    assign res     = core_out ^ ((op_reg == OP_DECRYPT) ? chain_cipher_reg : chain_plain_reg);

    assign eng_ctrl.start   = s_accept;
    assign eng_ctrl.decrypt = s_tuser[0];
    assign eng_ctrl.ack     = finish;

    xtea_engine #(
        .CNT_W (CNT_W)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (eng_ctrl),
        .rounds  (rounds),
        .key     (key_reg),
        .blk_in  (core_in),
        .stat    (eng_stat),
        .blk_out (core_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg         <= '0;
            round_count_reg <= ROUNDS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY0:   key_reg[0] <= cfg_wr_data;
                REG_KEY1:   key_reg[1] <= cfg_wr_data;
                REG_KEY2:   key_reg[2] <= cfg_wr_data;
                REG_KEY3:   key_reg[3] <= cfg_wr_data;
                REG_ROUNDS: round_count_reg <= cfg_wr_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_cipher_reg <= '0;
            chain_plain_reg  <= '0;
        end else if (s_accept) begin
            chain_cipher_reg <= cc_eff;
            chain_plain_reg  <= cp_eff;
        end else if (finish) begin
            if (op_reg == OP_DECRYPT) begin
                chain_cipher_reg <= blk_reg;
                chain_plain_reg  <= res;
            end else begin
                chain_cipher_reg <= res;
                chain_plain_reg  <= blk_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            blk_reg <= s_tdata;
            op_reg  <= s_tuser[0];
        end
        if (finish) begin
            m_data_reg <= res;
            m_tail_reg <= (res[63:8] == 56'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_tail_reg;

    `XTEA_ASSERT(a_busy_after_accept, s_accept |=> !s_tready, "ready right after a word")
    `XTEA_ASSERT(a_finish_shows, finish |=> m_tvalid, "finished word not presented")
    `XTEA_ASSERT_RST(a_reset_rounds, !aresetn |=> round_count_reg == ROUNDS_RESET, "bad reset")

endmodule

`default_nettype wire
